// ===== hw/rtl/dcirsp_pkg.sv =====
// Shared types, codes and constants for the scheduling-record stream parser.
// Used by the parser, the result register and the top level; depends on nothing.
package dcirsp_pkg;

  localparam int NUM_CELLS        = 4;
  localparam int MAX_CONFIG_CELLS = 4;

  localparam int CELL_IW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  localparam logic [7:0] NUM_CELLS_B = 8'(NUM_CELLS);
  localparam logic [7:0] MAX_CELLS_B = 8'(MAX_CONFIG_CELLS);

  localparam logic [7:0] PRE_BYTE_RECORD = 8'hAA;
  localparam logic [7:0] PRE_BYTE_CONFIG = 8'hBB;
  localparam logic [7:0] PRE_BYTE_EXIT   = 8'hFF;

  localparam int DIR_DL_BIT = 0;
  localparam int DIR_UL_BIT = 1;

  localparam int PRE_LEN      = 4;
  localparam int HDR_CELL_IDX = 11;
  localparam int HDR_TS_LAST  = 8;
  localparam int HDR_TICK_LO  = 9;
  localparam int HDR_TICK_HI  = 10;
  localparam int DIR_LAST_IDX = 4;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam int DATA_W = 248;
  localparam int USER_W = 3;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_DISCARD = 3'd1,
    PH_HDR     = 3'd2,
    PH_MASK    = 3'd3,
    PH_DL      = 3'd4,
    PH_UL      = 3'd5,
    PH_COUNT   = 3'd6,
    PH_ENTRY   = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    PRE_NONE   = 2'd0,
    PRE_RECORD = 2'd1,
    PRE_CONFIG = 2'd2,
    PRE_EXIT   = 2'd3
  } preamble_t;

  typedef enum logic [2:0] {
    KIND_RECORD = 3'd0,
    KIND_HEADER = 3'd1,
    KIND_ENTRY  = 3'd2,
    KIND_EXIT   = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [15:0] resource_blocks;
    logic [31:0] up_retx_total;
    logic [31:0] down_retx_total;
    logic [31:0] up_size;
    logic [7:0]  up_retx;
    logic [31:0] down_size;
    logic [7:0]  down_retx;
    logic [7:0]  cell_res;
    logic [15:0] tick;
    logic [63:0] rec_time;
    kind_t       kind;
  } result_t;

  function automatic logic [7:0] preamble_byte(preamble_t kind);
    logic [7:0] value;
    case (kind)
      PRE_RECORD: value = PRE_BYTE_RECORD;
      PRE_CONFIG: value = PRE_BYTE_CONFIG;
      PRE_EXIT:   value = PRE_BYTE_EXIT;
      default:    value = 8'h00;
    endcase
    return value;
  endfunction

endpackage

// ===== hw/rtl/dcirsp_parser.sv =====
// Parse state machine, field accumulators and per-cell retransmit counters.
// Steps once per word handed over by the top level; uses dcirsp_pkg.
module dcirsp_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                buffer_end,
  output logic                res_valid,
  output dcirsp_pkg::result_t res
);

  dcirsp_pkg::phase_t    phase, phase_next;
  dcirsp_pkg::preamble_t pre_kind, pre_kind_next;
  logic [3:0]  byte_counter, byte_counter_next;
  logic        ver_zero, ver_zero_next;
  logic [1:0]  dir_mask, dir_mask_next;
  logic [63:0] time_acc, time_acc_next;
  logic [15:0] tick_acc, tick_acc_next;
  logic [7:0]  cell_acc, cell_acc_next;
  logic [15:0] retx_acc, retx_acc_next;
  logic [63:0] size_acc, size_acc_next;
  logic [7:0]  entries_left, entries_left_next;
  logic        stopped, stopped_next;
  logic [31:0] down_counts [dcirsp_pkg::NUM_CELLS];
  logic [31:0] up_counts [dcirsp_pkg::NUM_CELLS];

  dcirsp_pkg::kind_t res_kind;
  logic        do_fail;
  logic        finish;
  logic [63:0] ts_shift;
  logic [31:0] part;
  logic [7:0]  entries_dec;

  logic                          cell_ok;
  logic [dcirsp_pkg::CELL_IW-1:0] cell_sel;
  logic [31:0] down_cur, up_cur, down_upd, up_upd;

  always_comb begin
    phase_next        = phase;
    pre_kind_next     = pre_kind;
    byte_counter_next = byte_counter;
    ver_zero_next     = ver_zero;
    dir_mask_next     = dir_mask;
    time_acc_next     = time_acc;
    tick_acc_next     = tick_acc;
    cell_acc_next     = cell_acc;
    retx_acc_next     = retx_acc;
    size_acc_next     = size_acc;
    entries_left_next = entries_left;
    stopped_next      = stopped;
    res_valid         = 1'b0;
    res_kind          = dcirsp_pkg::KIND_ERROR;
    do_fail           = 1'b0;
    finish            = 1'b0;
    ts_shift          = {time_acc[55:0], data_byte};
    part              = 32'h0;
    entries_dec       = entries_left - 8'd1;

    if (!stopped) begin
      case (phase)
        dcirsp_pkg::PH_HUNT: begin
          if (byte_counter == 4'd0) begin
            if (data_byte == dcirsp_pkg::PRE_BYTE_RECORD) begin
              pre_kind_next = dcirsp_pkg::PRE_RECORD;
            end else if (data_byte == dcirsp_pkg::PRE_BYTE_CONFIG) begin
              pre_kind_next = dcirsp_pkg::PRE_CONFIG;
            end else if (data_byte == dcirsp_pkg::PRE_BYTE_EXIT) begin
              pre_kind_next = dcirsp_pkg::PRE_EXIT;
            end else begin
              do_fail = 1'b1;
            end
          end else if (pre_kind == dcirsp_pkg::PRE_NONE ||
                       data_byte != dcirsp_pkg::preamble_byte(pre_kind)) begin
            do_fail = 1'b1;
          end
          if (!do_fail) begin
            if (byte_counter == 4'(dcirsp_pkg::PRE_LEN - 1)) begin
              byte_counter_next = 4'd0;
              if (pre_kind_next == dcirsp_pkg::PRE_EXIT) begin
                stopped_next = 1'b1;
                phase_next   = dcirsp_pkg::PH_HUNT;
                res_valid    = 1'b1;
                res_kind     = dcirsp_pkg::KIND_EXIT;
              end else if (buffer_end) begin
                do_fail = 1'b1;
              end else if (pre_kind_next == dcirsp_pkg::PRE_RECORD) begin
                phase_next    = dcirsp_pkg::PH_HDR;
                time_acc_next = 64'h0;
                tick_acc_next = 16'h0;
                cell_acc_next = 8'h0;
                retx_acc_next = 16'h0;
                size_acc_next = 64'h0;
                ver_zero_next = 1'b1;
                dir_mask_next = 2'b00;
              end else begin
                phase_next = dcirsp_pkg::PH_COUNT;
              end
            end else begin
              byte_counter_next = byte_counter + 4'd1;
              if (buffer_end) begin
                do_fail = 1'b1;
              end
            end
          end
        end
        dcirsp_pkg::PH_DISCARD: begin
          if (buffer_end) begin
            phase_next        = dcirsp_pkg::PH_HUNT;
            byte_counter_next = 4'd0;
          end
        end
        dcirsp_pkg::PH_HDR: begin
          if (byte_counter < 4'(dcirsp_pkg::HDR_CELL_IDX)) begin
            if (byte_counter == 4'd0) begin
              ver_zero_next = (data_byte == 8'h00);
            end else if (byte_counter < 4'(dcirsp_pkg::HDR_TICK_LO)) begin
              if (byte_counter == 4'(dcirsp_pkg::HDR_TS_LAST)) begin
                time_acc_next = {ts_shift[31:0], ts_shift[63:32]};
              end else begin
                time_acc_next = ts_shift;
              end
            end else if (byte_counter == 4'(dcirsp_pkg::HDR_TICK_LO)) begin
              tick_acc_next = {8'h00, data_byte};
            end else if (byte_counter == 4'(dcirsp_pkg::HDR_TICK_HI)) begin
              tick_acc_next = {data_byte, tick_acc[7:0]};
            end
            if (buffer_end) begin
              do_fail = 1'b1;
            end else begin
              byte_counter_next = byte_counter + 4'd1;
            end
          end else begin
            cell_acc_next = data_byte;
            if (data_byte >= dcirsp_pkg::NUM_CELLS_B) begin
              do_fail = 1'b1;
            end else if (!ver_zero) begin
              finish = 1'b1;
            end else if (buffer_end) begin
              do_fail = 1'b1;
            end else begin
              phase_next        = dcirsp_pkg::PH_MASK;
              byte_counter_next = 4'd0;
            end
          end
        end
        dcirsp_pkg::PH_MASK: begin
          dir_mask_next     = data_byte[1:0];
          byte_counter_next = 4'd0;
          if (data_byte[dcirsp_pkg::DIR_DL_BIT]) begin
            phase_next = dcirsp_pkg::PH_DL;
          end else if (data_byte[dcirsp_pkg::DIR_UL_BIT]) begin
            phase_next = dcirsp_pkg::PH_UL;
          end else begin
            finish = 1'b1;
          end
          if (!finish && buffer_end) begin
            do_fail = 1'b1;
          end
        end
        dcirsp_pkg::PH_DL, dcirsp_pkg::PH_UL: begin
          if (phase == dcirsp_pkg::PH_UL) begin
            part = size_acc[63:32];
          end else begin
            part = size_acc[31:0];
          end
          if (byte_counter == 4'd0) begin
            if (phase == dcirsp_pkg::PH_UL) begin
              retx_acc_next = {data_byte, retx_acc[7:0]};
            end else begin
              retx_acc_next = {retx_acc[15:8], data_byte};
            end
          end else if (phase == dcirsp_pkg::PH_UL) begin
            size_acc_next = {part[23:0], data_byte, size_acc[31:0]};
          end else begin
            size_acc_next = {size_acc[63:32], part[23:0], data_byte};
          end
          if (byte_counter == 4'(dcirsp_pkg::DIR_LAST_IDX)) begin
            byte_counter_next = 4'd0;
            if (phase == dcirsp_pkg::PH_DL && dir_mask[dcirsp_pkg::DIR_UL_BIT]) begin
              phase_next = dcirsp_pkg::PH_UL;
            end else begin
              finish = 1'b1;
            end
          end else begin
            byte_counter_next = byte_counter + 4'd1;
          end
          if (!finish && buffer_end) begin
            do_fail = 1'b1;
          end
        end
        dcirsp_pkg::PH_COUNT: begin
          if (data_byte > dcirsp_pkg::MAX_CELLS_B) begin
            do_fail = 1'b1;
          end else begin
            cell_acc_next     = data_byte;
            entries_left_next = data_byte;
            byte_counter_next = 4'd0;
            if (data_byte != 8'h00) begin
              if (buffer_end) begin
                do_fail = 1'b1;
              end else begin
                phase_next = dcirsp_pkg::PH_ENTRY;
              end
            end else begin
              phase_next = dcirsp_pkg::PH_HUNT;
            end
            if (!do_fail) begin
              res_valid = 1'b1;
              res_kind  = dcirsp_pkg::KIND_HEADER;
            end
          end
        end
        dcirsp_pkg::PH_ENTRY: begin
          if (byte_counter == 4'd0) begin
            tick_acc_next = {8'h00, data_byte};
            if (buffer_end) begin
              do_fail = 1'b1;
            end else begin
              byte_counter_next = 4'd1;
            end
          end else begin
            entries_left_next = entries_dec;
            byte_counter_next = 4'd0;
            if (entries_dec == 8'h00) begin
              phase_next = dcirsp_pkg::PH_HUNT;
            end else if (buffer_end) begin
              do_fail = 1'b1;
            end
            if (!do_fail) begin
              res_valid = 1'b1;
              res_kind  = dcirsp_pkg::KIND_ENTRY;
            end
          end
        end
        default: begin
          phase_next        = dcirsp_pkg::PH_HUNT;
          byte_counter_next = 4'd0;
        end
      endcase

      if (do_fail) begin
        phase_next        = buffer_end ? dcirsp_pkg::PH_HUNT : dcirsp_pkg::PH_DISCARD;
        byte_counter_next = 4'd0;
        res_valid         = 1'b1;
        res_kind          = dcirsp_pkg::KIND_ERROR;
      end else if (finish) begin
        phase_next        = dcirsp_pkg::PH_HUNT;
        byte_counter_next = 4'd0;
        res_valid         = 1'b1;
        res_kind          = dcirsp_pkg::KIND_RECORD;
      end
    end
  end

  assign cell_ok  = (cell_acc_next < dcirsp_pkg::NUM_CELLS_B);
  assign cell_sel = cell_acc_next[dcirsp_pkg::CELL_IW-1:0];

  always_comb begin
    down_cur = cell_ok ? down_counts[cell_sel] : 32'h0;
    up_cur   = cell_ok ? up_counts[cell_sel] : 32'h0;
    down_upd = down_cur;
    up_upd   = up_cur;
    if (retx_acc_next[7:0] != 8'h00 && down_cur != dcirsp_pkg::COUNT_MAX) begin
      down_upd = down_cur + 32'd1;
    end
    if (retx_acc_next[15:8] != 8'h00 && up_cur != dcirsp_pkg::COUNT_MAX) begin
      up_upd = up_cur + 32'd1;
    end

    res      = '0;
    res.kind = res_kind;
    case (res_kind)
      dcirsp_pkg::KIND_RECORD: begin
        res.rec_time        = time_acc_next;
        res.tick            = tick_acc_next;
        res.cell_res        = cell_acc_next;
        res.down_retx       = retx_acc_next[7:0];
        res.down_size       = size_acc_next[31:0];
        res.up_retx         = retx_acc_next[15:8];
        res.up_size         = size_acc_next[63:32];
        res.down_retx_total = down_upd;
        res.up_retx_total   = up_upd;
      end
      dcirsp_pkg::KIND_HEADER: begin
        res.cell_res = data_byte;
      end
      dcirsp_pkg::KIND_ENTRY: begin
        res.cell_res        = cell_acc - entries_left;
        res.resource_blocks = {data_byte, tick_acc[7:0]};
      end
      default: begin
        res.cell_res = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= dcirsp_pkg::PH_HUNT;
      pre_kind     <= dcirsp_pkg::PRE_NONE;
      byte_counter <= 4'd0;
      ver_zero     <= 1'b1;
      dir_mask     <= 2'b00;
      time_acc     <= 64'h0;
      tick_acc     <= 16'h0;
      cell_acc     <= 8'h0;
      retx_acc     <= 16'h0;
      size_acc     <= 64'h0;
      entries_left <= 8'h0;
      stopped      <= 1'b0;
      for (int i = 0; i < dcirsp_pkg::NUM_CELLS; i++) begin
        down_counts[i] <= 32'h0;
        up_counts[i]   <= 32'h0;
      end
    end else if (step) begin
      phase        <= phase_next;
      pre_kind     <= pre_kind_next;
      byte_counter <= byte_counter_next;
      ver_zero     <= ver_zero_next;
      dir_mask     <= dir_mask_next;
      time_acc     <= time_acc_next;
      tick_acc     <= tick_acc_next;
      cell_acc     <= cell_acc_next;
      retx_acc     <= retx_acc_next;
      size_acc     <= size_acc_next;
      entries_left <= entries_left_next;
      stopped      <= stopped_next;
      if (finish && !do_fail && cell_ok) begin
        down_counts[cell_sel] <= down_upd;
        up_counts[cell_sel]   <= up_upd;
      end
    end
  end

endmodule

// ===== hw/rtl/dcirsp_out_reg.sv =====
// Result register on the master side; packs result fields onto tdata and tuser.
// Uses the result type of dcirsp_pkg.
module dcirsp_out_reg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  dcirsp_pkg::result_t              load_res,
  output logic                             can_load,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // rec_time, tick, cell_res, down_retx, down_size, up_retx, up_size,
  // down_retx_total, up_retx_total, resource_blocks
  output logic [dcirsp_pkg::DATA_W-1:0]    m_axis_tdata,
  // kind
  output logic [dcirsp_pkg::USER_W-1:0]    m_axis_tuser
);

  dcirsp_pkg::result_t held;
  logic                valid;

  assign can_load = !valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (can_load) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= load_res;
    end
  end

  assign m_axis_tvalid = valid;
  assign m_axis_tuser  = held.kind;
  assign m_axis_tdata  = {held.resource_blocks, held.up_retx_total, held.down_retx_total,
                          held.up_size, held.up_retx, held.down_size, held.down_retx,
                          held.cell_res, held.tick, held.rec_time};

endmodule

// ===== hw/rtl/dci_record_stream_parser_core.sv =====
// Top level of the scheduling-record stream parser: input word register,
// parser and result register. Uses dcirsp_pkg, dcirsp_parser, dcirsp_out_reg.

// The block takes one byte per word on the slave side, with tlast on the last
// byte of each received buffer, and gives at most one result per byte on the
// master side, its kind in tuser. It sustains one byte per clock cycle while
// the master side takes its results; a byte is held in the input register, and
// the combinational parse step writes its result into the result register.
// Backpressure on the master side holds the parse step, and while a result
// waits to be taken one more byte can still be accepted if the input register
// is empty.
module dci_record_stream_parser_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // data_byte
  input  logic [7:0]                    s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rec_time, tick, cell_res, down_retx, down_size, up_retx, up_size,
  // down_retx_total, up_retx_total, resource_blocks
  output logic [dcirsp_pkg::DATA_W-1:0] m_axis_tdata,
  // kind
  output logic [dcirsp_pkg::USER_W-1:0] m_axis_tuser
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_last;
  logic                step;
  logic                can_load;
  logic                res_valid;
  dcirsp_pkg::result_t res;

  assign step          = in_valid && can_load;
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  dcirsp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (in_byte),
    .buffer_end (in_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  dcirsp_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .load_res      (res),
    .can_load      (can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== bench/dci_record_stream_parser_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for dci_record_stream_parser_core: streams record, configuration,
// exit and malformed buffers and checks every result word against a built-in parser model.
// Depends on dcirsp_pkg and the RTL of the parser core.
module dci_record_stream_parser_core_tb;
  import dcirsp_pkg::*;

  typedef struct {
    logic [7:0] value;
    logic       last;
    bit         drain_first;
  } stream_word_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'h00;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [DATA_W-1:0]   m_axis_tdata;
  logic [USER_W-1:0]   m_axis_tuser;

  stream_word_t pending_words[$];
  logic [7:0]   frame_bytes[$];
  result_t      expected_results[$];

  int unsigned cyc = 0;
  int          bytes_in = 0;
  int          bytes_shown = 0;
  int          words_planned = 0;
  int          results_seen = 0;
  int          mismatches = 0;
  int          kind_count[5] = '{0, 0, 0, 0, 0};
  int          stall_left = 0;
  bit          stall_done = 1'b0;
  logic        calm;

  // Parser model state.
  phase_t      phase = PH_HUNT;
  preamble_t   pre = PRE_NONE;
  logic [7:0]  cnt = '0;
  logic [7:0]  version = '0;
  logic [1:0]  dirmask = '0;
  logic [63:0] ts_acc = '0;
  logic [15:0] tk_acc = '0;
  logic [7:0]  cell_q = '0;
  logic [15:0] retx_q = '0;
  logic [63:0] size_q = '0;
  logic [7:0]  left_q = '0;
  logic [31:0] dl_total[NUM_CELLS] = '{default: '0};
  logic [31:0] ul_total[NUM_CELLS] = '{default: '0};
  bit          halted = 1'b0;

  dci_record_stream_parser_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  assign calm = (cyc >= 800) && (cyc < 1300);

  task automatic parse_byte(input logic [7:0] b, input logic last,
                            output bit produced, output result_t res);
    logic [7:0] k;
    logic [7:0] want_b;
    logic [7:0] dr;
    logic [7:0] ur;
    bit         up;
    bit         err;
    bit         done;
    k = cnt;
    res = '0;
    produced = 1'b0;
    err = 1'b0;
    done = 1'b0;
    if (halted) return;
    case (phase)
      PH_HUNT: begin
        if (k == 0) begin
          if (b == PRE_BYTE_RECORD) pre = PRE_RECORD;
          else if (b == PRE_BYTE_CONFIG) pre = PRE_CONFIG;
          else if (b == PRE_BYTE_EXIT) pre = PRE_EXIT;
          else err = 1'b1;
        end else begin
          case (pre)
            PRE_RECORD: want_b = PRE_BYTE_RECORD;
            PRE_CONFIG: want_b = PRE_BYTE_CONFIG;
            PRE_EXIT:   want_b = PRE_BYTE_EXIT;
            default:    want_b = 8'h00;
          endcase
          if (pre == PRE_NONE || b != want_b) err = 1'b1;
        end
        if (!err) begin
          k = k + 1;
          cnt = k;
          if (k >= PRE_LEN) begin
            cnt = '0;
            if (pre == PRE_EXIT) begin
              halted = 1'b1;
              produced = 1'b1;
              res.kind = KIND_EXIT;
            end else if (last) begin
              err = 1'b1;
            end else if (pre == PRE_RECORD) begin
              phase = PH_HDR;
              ts_acc = '0;
              tk_acc = '0;
              cell_q = '0;
              retx_q = '0;
              size_q = '0;
              version = '0;
              dirmask = '0;
            end else begin
              phase = PH_COUNT;
            end
          end else if (last) begin
            err = 1'b1;
          end
        end
      end
      PH_DISCARD: begin
        if (last) begin
          phase = PH_HUNT;
          cnt = '0;
        end
      end
      PH_HDR: begin
        if (k == 0) version = b;
        else if (k <= HDR_TS_LAST) begin
          ts_acc = {ts_acc[55:0], b};
          if (k == HDR_TS_LAST) ts_acc = {ts_acc[31:0], ts_acc[63:32]};
        end else if (k == HDR_TICK_LO) tk_acc = {8'h00, b};
        else if (k == HDR_TICK_HI) tk_acc[15:8] = b;
        else begin
          cell_q = b;
          if (b >= NUM_CELLS_B) err = 1'b1;
          else if (version != 8'h00) done = 1'b1;
          else if (last) err = 1'b1;
          else begin
            phase = PH_MASK;
            cnt = '0;
          end
        end
        if (k < HDR_CELL_IDX) begin
          if (last) err = 1'b1;
          else cnt = k + 1;
        end
      end
      PH_MASK: begin
        dirmask = b[1:0];
        cnt = '0;
        if (dirmask[DIR_DL_BIT]) phase = PH_DL;
        else if (dirmask[DIR_UL_BIT]) phase = PH_UL;
        else done = 1'b1;
        if (!done && last) err = 1'b1;
      end
      PH_DL, PH_UL: begin
        up = (phase == PH_UL);
        if (k == 0) begin
          if (up) retx_q[15:8] = b;
          else retx_q[7:0] = b;
        end else if (up) begin
          size_q[63:32] = {size_q[55:32], b};
        end else begin
          size_q[31:0] = {size_q[23:0], b};
        end
        if (k >= DIR_LAST_IDX) begin
          cnt = '0;
          if (!up && dirmask[DIR_UL_BIT]) phase = PH_UL;
          else done = 1'b1;
        end else begin
          cnt = k + 1;
        end
        if (!done && last) err = 1'b1;
      end
      PH_COUNT: begin
        if (b > MAX_CELLS_B) err = 1'b1;
        else begin
          cell_q = b;
          left_q = b;
          cnt = '0;
          if (b > 0) begin
            if (last) err = 1'b1;
            else phase = PH_ENTRY;
          end else begin
            phase = PH_HUNT;
          end
          if (!err) begin
            produced = 1'b1;
            res.kind = KIND_HEADER;
            res.cell_res = b;
          end
        end
      end
      PH_ENTRY: begin
        if (k == 0) begin
          tk_acc = {8'h00, b};
          if (last) err = 1'b1;
          else cnt = 8'd1;
        end else begin
          res.resource_blocks = {b, tk_acc[7:0]};
          res.cell_res = cell_q - left_q;
          left_q = left_q - 1;
          cnt = '0;
          if (left_q == 0) phase = PH_HUNT;
          else if (last) err = 1'b1;
          if (!err) begin
            produced = 1'b1;
            res.kind = KIND_ENTRY;
          end
        end
      end
      default: begin
        phase = PH_HUNT;
        cnt = '0;
      end
    endcase
    if (done) begin
      dr = retx_q[7:0];
      ur = retx_q[15:8];
      res = '0;
      if (cell_q < NUM_CELLS_B) begin
        if (dr != 0 && dl_total[cell_q] != COUNT_MAX) dl_total[cell_q] = dl_total[cell_q] + 1;
        if (ur != 0 && ul_total[cell_q] != COUNT_MAX) ul_total[cell_q] = ul_total[cell_q] + 1;
        res.down_retx_total = dl_total[cell_q];
        res.up_retx_total = ul_total[cell_q];
      end
      res.kind = KIND_RECORD;
      res.rec_time = ts_acc;
      res.tick = tk_acc;
      res.cell_res = cell_q;
      res.down_retx = dr;
      res.down_size = size_q[31:0];
      res.up_retx = ur;
      res.up_size = size_q[63:32];
      phase = PH_HUNT;
      cnt = '0;
      produced = 1'b1;
    end
    if (err) begin
      phase = last ? PH_HUNT : PH_DISCARD;
      cnt = '0;
      res = '0;
      res.kind = KIND_ERROR;
      produced = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 100)
      $display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result(input result_t seen, input result_t want);
    if (seen.kind != want.kind) report_mismatch("kind", seen.kind, want.kind);
    if (seen.rec_time != want.rec_time)
      report_mismatch("rec_time", seen.rec_time, want.rec_time);
    if (seen.tick != want.tick) report_mismatch("tick", seen.tick, want.tick);
    if (seen.cell_res != want.cell_res) report_mismatch("cell_res", seen.cell_res, want.cell_res);
    if (seen.down_retx != want.down_retx)
      report_mismatch("down_retx", seen.down_retx, want.down_retx);
    if (seen.down_size != want.down_size)
      report_mismatch("down_size", seen.down_size, want.down_size);
    if (seen.up_retx != want.up_retx) report_mismatch("up_retx", seen.up_retx, want.up_retx);
    if (seen.up_size != want.up_size) report_mismatch("up_size", seen.up_size, want.up_size);
    if (seen.down_retx_total != want.down_retx_total)
      report_mismatch("down_retx_total", seen.down_retx_total, want.down_retx_total);
    if (seen.up_retx_total != want.up_retx_total)
      report_mismatch("up_retx_total", seen.up_retx_total, want.up_retx_total);
    if (seen.resource_blocks != want.resource_blocks)
      report_mismatch("resource_blocks", seen.resource_blocks, want.resource_blocks);
  endtask

  function automatic logic [63:0] pick_value(input int bits);
    logic [63:0] mask;
    mask = (bits >= 64) ? '1 : ((64'd1 << bits) - 1);
    case ($urandom_range(7))
      0:       return 64'd0;
      1:       return mask;
      default: return {$urandom, $urandom} & mask;
    endcase
  endfunction

  task automatic put_be32(input logic [31:0] v);
    frame_bytes.push_back(v[31:24]);
    frame_bytes.push_back(v[23:16]);
    frame_bytes.push_back(v[15:8]);
    frame_bytes.push_back(v[7:0]);
  endtask

  task automatic add_record(input logic [7:0] ver, input logic [63:0] stamp,
                            input logic [15:0] tk, input logic [7:0] cell_no,
                            input logic [7:0] mask, input logic [7:0] dl_retx,
                            input logic [31:0] dl_size, input logic [7:0] ul_retx,
                            input logic [31:0] ul_size);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_RECORD);
    frame_bytes.push_back(ver);
    put_be32(stamp[31:0]);
    put_be32(stamp[63:32]);
    frame_bytes.push_back(tk[7:0]);
    frame_bytes.push_back(tk[15:8]);
    frame_bytes.push_back(cell_no);
    if (ver == 8'h00) begin
      frame_bytes.push_back(mask);
      if (mask[DIR_DL_BIT]) begin
        frame_bytes.push_back(dl_retx);
        put_be32(dl_size);
      end
      if (mask[DIR_UL_BIT]) begin
        frame_bytes.push_back(ul_retx);
        put_be32(ul_size);
      end
    end
  endtask

  task automatic add_config(input logic [7:0] count, input logic [15:0] entry,
                            input bit random_entries);
    logic [15:0] rb;
    int          n;
    n = (count > MAX_CELLS_B) ? 2 : int'(count);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_CONFIG);
    frame_bytes.push_back(count);
    for (int i = 0; i < n; i++) begin
      rb = random_entries ? 16'(pick_value(16)) : entry;
      frame_bytes.push_back(rb[7:0]);
      frame_bytes.push_back(rb[15:8]);
    end
  endtask

  task automatic close_buffer(input int keep, input bit drain_first);
    stream_word_t w;
    int           n;
    n = (keep > 0 && keep < frame_bytes.size()) ? keep : frame_bytes.size();
    for (int i = 0; i < n; i++) begin
      w.value = frame_bytes[i];
      w.last = (i == n - 1);
      w.drain_first = drain_first && (i == 0);
      pending_words.push_back(w);
    end
    frame_bytes.delete();
  endtask

  always @(negedge clk) begin : sender
    stream_word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (bytes_in == bytes_shown) begin
      if (pending_words.size() == 0 || (!calm && $urandom_range(99) < 21) ||
          (pending_words[0].drain_first && expected_results.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w.value;
        s_axis_tlast <= w.last;
        bytes_shown++;
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!stall_done && bytes_in >= 300) begin
      stall_done = 1'b1;
      stall_left = 150;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin : monitor
    result_t seen;
    result_t guess;
    result_t oldest;
    bit      made;
    cyc++;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_in++;
        parse_byte(s_axis_tdata, s_axis_tlast, made, guess);
        if (made) expected_results.push_back(guess);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'({m_axis_tdata, m_axis_tuser});
        results_seen++;
        if (int'(seen.kind) < 5) kind_count[int'(seen.kind)]++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no expectation, kind", seen.kind, '0);
        end else begin
          oldest = expected_results.pop_front();
          compare_result(seen, oldest);
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    int frames;
    int f;
    int sel;
    int keep;
    bit drain_used;

    // Extremes of every field and both link directions.
    add_record(8'h00, '0, '0, 8'h00, 8'h03, 8'h00, '0, 8'h00, '0);
    close_buffer(0, 1'b0);
    add_record(8'h00, '1, 16'hFFFF, 8'h03, 8'hFF, 8'hFF, '1, 8'hFF, '1);
    close_buffer(0, 1'b0);
    add_record(8'h00, 64'h0123_4567_89AB_CDEF, 16'h1234, 8'h01, 8'h01, 8'h05,
               32'h0000_1000, 8'h00, '0);
    add_record(8'h00, 64'hFEDC_BA98_7654_3210, 16'h8001, 8'h02, 8'h02, 8'h00, '0,
               8'h80, 32'h8000_0001);
    close_buffer(0, 1'b0);
    add_record(8'h00, 64'h5555_AAAA_0F0F_F0F0, 16'h00FF, 8'h02, 8'hFC, 8'h00, '0, 8'h00, '0);
    add_config(8'h00, '0, 1'b0);
    close_buffer(0, 1'b0);
    add_record(8'h01, 64'h1111_2222_3333_4444, 16'hABCD, 8'h03, 8'h00, 8'h00, '0, 8'h00, '0);
    add_record(8'hFF, 64'h8000_0000_0000_0001, 16'h0001, 8'h00, 8'h00, 8'h00, '0, 8'h00, '0);
    close_buffer(0, 1'b0);

    // Cell index out of range, with the rest of the buffer dropped.
    add_record(8'h00, '1, 16'h4242, NUM_CELLS_B, 8'h03, 8'h01, '1, 8'h01, '1);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_EXIT);
    close_buffer(0, 1'b0);
    add_record(8'h07, '0, '0, 8'hFF, 8'h00, 8'h00, '0, 8'h00, '0);
    close_buffer(0, 1'b0);

    // Cell configurations, including counts above the limit.
    add_config(MAX_CELLS_B, 16'hFFFF, 1'b0);
    close_buffer(0, 1'b0);
    add_config(8'h01, 16'h0000, 1'b0);
    close_buffer(0, 1'b0);
    add_config(MAX_CELLS_B + 8'd1, '0, 1'b1);
    close_buffer(0, 1'b0);
    add_config(8'hFF, '0, 1'b1);
    close_buffer(0, 1'b0);

    // Unknown and mismatched preambles.
    frame_bytes = '{8'h00};
    close_buffer(0, 1'b0);
    frame_bytes = '{8'h55, PRE_BYTE_EXIT, PRE_BYTE_EXIT, PRE_BYTE_EXIT, PRE_BYTE_EXIT, 8'h01};
    close_buffer(0, 1'b0);
    frame_bytes = '{PRE_BYTE_RECORD, PRE_BYTE_RECORD, PRE_BYTE_CONFIG, 8'h00};
    close_buffer(0, 1'b0);
    frame_bytes = '{PRE_BYTE_CONFIG, PRE_BYTE_RECORD};
    close_buffer(0, 1'b0);
    frame_bytes = '{PRE_BYTE_EXIT, PRE_BYTE_EXIT, 8'h00, 8'h00};
    close_buffer(0, 1'b0);

    // Buffers that end before a preamble, record or configuration is complete.
    frame_bytes = '{PRE_BYTE_RECORD, PRE_BYTE_RECORD};
    close_buffer(0, 1'b0);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_RECORD);
    close_buffer(0, 1'b0);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_CONFIG);
    close_buffer(0, 1'b0);
    frame_bytes = '{PRE_BYTE_EXIT, PRE_BYTE_EXIT, PRE_BYTE_EXIT};
    close_buffer(0, 1'b0);
    add_record(8'h00, 64'hCAFE_0000_1234_5678, 16'h0102, 8'h01, 8'h03, 8'h09, 32'h10, 8'h09, 32'h20);
    close_buffer(9, 1'b0);
    add_record(8'h00, 64'hCAFE_0000_1234_5678, 16'h0102, 8'h01, 8'h03, 8'h09, 32'h10, 8'h09, 32'h20);
    close_buffer(16, 1'b0);
    add_record(8'h00, 64'hCAFE_0000_1234_5678, 16'h0102, 8'h01, 8'h03, 8'h09, 32'h10, 8'h09, 32'h20);
    close_buffer(17, 1'b0);
    add_record(8'h00, 64'hCAFE_0000_1234_5678, 16'h0102, 8'h01, 8'h03, 8'h09, 32'h10, 8'h09, 32'h20);
    close_buffer(22, 1'b0);
    add_config(8'h02, 16'h8001, 1'b0);
    close_buffer(5, 1'b0);
    add_config(8'h02, 16'h8001, 1'b0);
    close_buffer(6, 1'b0);
    add_config(8'h02, 16'h8001, 1'b0);
    close_buffer(7, 1'b0);

    // Random buffers: mostly well-formed frames, some broken, some cut short.
    base = pending_words.size();
    drain_used = 1'b0;
    while (pending_words.size() - base < 1000) begin
      frames = $urandom_range(1, 3);
      f = 0;
      while (f < frames) begin
        sel = $urandom_range(99);
        if (sel < 50) begin
          add_record(($urandom_range(99) < 70) ? 8'h00 : 8'($urandom_range(1, 255)),
                     pick_value(64), 16'(pick_value(16)),
                     ($urandom_range(99) < 90) ? 8'($urandom_range(0, NUM_CELLS - 1))
                                               : 8'($urandom_range(NUM_CELLS, 255)),
                     8'($urandom), 8'(pick_value(8)), 32'(pick_value(32)),
                     8'(pick_value(8)), 32'(pick_value(32)));
        end else if (sel < 78) begin
          add_config(($urandom_range(99) < 90) ? 8'($urandom_range(0, MAX_CONFIG_CELLS))
                                               : 8'($urandom_range(MAX_CONFIG_CELLS + 1, 255)),
                     '0, 1'b1);
        end else if (sel < 88) begin
          repeat ($urandom_range(1, PRE_LEN - 1)) frame_bytes.push_back(PRE_BYTE_EXIT);
          frame_bytes.push_back(8'($urandom_range(0, 254)));
        end else begin
          // Noise never holds the exit byte, so it cannot stop the block.
          repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 254)));
          f = frames;
        end
        f++;
      end
      keep = ($urandom_range(99) < 15) ? $urandom_range(1, frame_bytes.size()) : 0;
      if (!drain_used && pending_words.size() - base > 700) begin
        close_buffer(keep, 1'b1);
        drain_used = 1'b1;
      end else begin
        close_buffer(keep, 1'b0);
      end
    end

    // Exit, after which everything is ignored.
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_EXIT);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_RECORD);
    frame_bytes.push_back(8'h00);
    repeat (PRE_LEN) frame_bytes.push_back(PRE_BYTE_EXIT);
    close_buffer(0, 1'b1);
    frame_bytes = '{8'h00};
    close_buffer(0, 1'b0);
    words_planned = pending_words.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (bytes_in == words_planned);
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes over %0d cycles; checked %0d results, %0d mismatches.",
             bytes_in, cyc, results_seen, mismatches);
    $display("Results: %0d records, %0d headers, %0d entries, %0d exits, %0d errors.",
             kind_count[KIND_RECORD], kind_count[KIND_HEADER], kind_count[KIND_ENTRY],
             kind_count[KIND_EXIT], kind_count[KIND_ERROR]);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("Timeout: %0d of %0d bytes accepted, %0d results still expected.",
             bytes_in, words_planned, expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
